[hw/rtl/o2vpi_pkg.sv]
// Shared types and constants for the oxygen valve PI controller.
package o2vpi_pkg;

	// Input sample beat
	typedef struct packed {
		logic signed [15:0] setpoint;
		logic signed [15:0] measured_flow;
		logic [15:0]        adjust_setting;
		logic               full_oxygen_mode;
		logic               maintenance_on;
	} o2vpi_sample_t;

	// Result beat
	typedef struct packed {
		logic [15:0] valve_drive;
		logic [15:0] valve_command;
	} o2vpi_result_t;

	// Configuration register file
	typedef struct packed {
		logic [15:0]        prop_gain;
		logic [15:0]        integral_gain;
		logic [19:0]        integral_max;
		logic signed [20:0] integral_min;
		logic [15:0]        off_level;
		logic [15:0]        adjust_floor;
	} o2vpi_cfg_t;

	// Stage load strobes handed to the datapath modules
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic acc_upd;
		logic ld_s5;
		logic ld_s6;
	} o2vpi_ctl_t;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_MAX  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_MIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ADJUST_FLOOR  = 3'd5;

	// Reset values
	localparam logic [19:0] INTEGRAL_MAX_RST = 20'd655350;
	localparam logic [15:0] OFF_LEVEL_RST    = 16'd65535;
	localparam logic [15:0] ADJUST_FLOOR_RST = 16'd21;

	// Datapath widths
	localparam int ERR_W  = 17;
	localparam int TERM_W = 24;
	localparam int ACC_W  = 22;
	localparam int QUOT_W = 20;

	// x/1000 == ((x >> 3) * DIV125_MUL) >> DIV125_SHIFT, exact for x < 2^32
	localparam logic [29:0] DIV125_MUL   = 30'd549755814;
	localparam int          DIV125_SHIFT = 36;

	// x/10 == ((x >> 1) * DIV5_MUL) >> DIV5_SHIFT, exact for x < 2^23
	localparam logic [22:0] DIV5_MUL   = 23'd6710887;
	localparam int          DIV5_SHIFT = 25;

	// Same for the 20-bit clamp limit, exact for x < 2^20
	localparam logic [19:0] CAP_DIV5_MUL   = 20'd838861;
	localparam int          CAP_DIV5_SHIFT = 22;

endpackage

[hw/rtl/o2vpi_gain_term.sv]
// Gain times error, then divided by 1000 truncating toward zero (two stages).
module o2vpi_gain_term (
	input  logic                                  clk,
	input  logic                                  ld_s2,
	input  logic                                  ld_s3,
	input  logic [15:0]                           gain,
	input  logic signed [o2vpi_pkg::ERR_W-1:0]    err,
	output logic signed [o2vpi_pkg::TERM_W-1:0]   term_s3
);

	localparam int TERM_W = o2vpi_pkg::TERM_W;

	logic signed [33:0] prod_s2;
	logic [33:0]        mag_full;
	logic [28:0]        scaled;
	logic [58:0]        recip;
	logic [22:0]        quot;
	logic [o2vpi_pkg::TERM_W-1:0] term_mag;

	// Stage 2: signed product, magnitude stays below 2^32
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			prod_s2 <= $signed({1'b0, gain}) * err;
		end
	end

	// Divide the magnitude by 1000 through a reciprocal multiply
	always_comb begin
		mag_full = prod_s2[33] ? 34'(-prod_s2) : prod_s2;
		scaled   = mag_full[31:3];
		recip    = scaled * o2vpi_pkg::DIV125_MUL;
		quot     = recip[58:o2vpi_pkg::DIV125_SHIFT];
		term_mag = {1'b0, quot};
	end

	// Stage 3: restore the sign
	always_ff @(posedge clk) begin
		if (ld_s3) begin
			term_s3 <= prod_s2[33] ? TERM_W'(-term_mag) : term_mag;
		end
	end

endmodule

[hw/rtl/o2vpi_integrator.sv]
// Integral accumulator with min/max clamp; carries the proportional term alongside.
module o2vpi_integrator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  o2vpi_pkg::o2vpi_ctl_t                 ctl,
	input  logic signed [o2vpi_pkg::TERM_W-1:0]   prop_s3,
	input  logic signed [o2vpi_pkg::TERM_W-1:0]   inc_s3,
	input  logic [19:0]                           integral_max,
	input  logic signed [20:0]                    integral_min,
	output logic signed [o2vpi_pkg::TERM_W-1:0]   prop_s4,
	output logic signed [o2vpi_pkg::ACC_W-1:0]    acc_s4
);

	logic signed [o2vpi_pkg::ACC_W-1:0] acc_q;
	logic signed [o2vpi_pkg::ACC_W-1:0] acc_next;
	logic signed [24:0] sum;
	logic signed [24:0] max_ext;
	logic signed [24:0] min_ext;
	logic signed [24:0] hi_clamped;
	logic signed [24:0] lo_clamped;

	// Add the increment, clamp to max first and then to min
	always_comb begin
		max_ext    = {5'b00000, integral_max};
		min_ext    = {{4{integral_min[20]}}, integral_min};
		sum        = {{3{acc_q[21]}}, acc_q} + {inc_s3[23], inc_s3};
		hi_clamped = (sum > max_ext) ? max_ext : sum;
		lo_clamped = (hi_clamped < min_ext) ? min_ext : hi_clamped;
		acc_next   = lo_clamped[o2vpi_pkg::ACC_W-1:0];
	end

	// Accumulator state: advance once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_upd) begin
			acc_q <= acc_next;
		end
	end

	// Stage 4 copies for the command path
	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			prop_s4 <= prop_s3;
			acc_s4  <= acc_next;
		end
	end

`ifndef NO_ASSERTIONS
	// The accumulator moves only on a sample update
	assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.acc_upd |=> $stable(acc_q))
		else $error("integral accumulator changed without a sample");

	// An update lands at or below the max clamp, or exactly on the min clamp
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_upd |=> ($signed({{3{acc_q[21]}}, acc_q}) <= $past(max_ext)
			|| $signed({{3{acc_q[21]}}, acc_q}) == $past(min_ext)))
		else $error("integral accumulator outside its clamp range");
`endif

endmodule

[hw/rtl/o2vpi_cmd_out.sv]
// Command scaling by 1/10, saturation and valve drive selection (two stages).
module o2vpi_cmd_out (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  o2vpi_pkg::o2vpi_ctl_t                 ctl,
	input  logic signed [o2vpi_pkg::TERM_W-1:0]   prop_s4,
	input  logic signed [o2vpi_pkg::ACC_W-1:0]    acc_s4,
	input  logic                                  en_s4,
	input  logic [19:0]                           integral_max,
	input  logic [15:0]                           off_level,
	output o2vpi_pkg::o2vpi_result_t              result_s6
);

	logic signed [24:0] total;
	logic [21:0]        half;
	logic [44:0]        recip;
	logic [o2vpi_pkg::QUOT_W-1:0] quot;
	logic [o2vpi_pkg::QUOT_W-1:0] quot_s5;
	logic               en_s5;
	logic [38:0]        cap_recip;
	logic [16:0]        cap_full;
	logic [15:0]        cap_q;
	logic [15:0]        cmd;
	logic [15:0]        drive;

	// Command ceiling: integral_max/10, held to 16 bits
	always_comb begin
		cap_recip = integral_max[19:1] * o2vpi_pkg::CAP_DIV5_MUL;
		cap_full  = cap_recip[38:o2vpi_pkg::CAP_DIV5_SHIFT];
	end

	always_ff @(posedge clk) begin
		cap_q <= cap_full[16] ? 16'hFFFF : cap_full[15:0];
	end

	// Sum and divide by 10; a negative sum gives zero
	always_comb begin
		total = {prop_s4[23], prop_s4} + {{3{acc_s4[21]}}, acc_s4};
		half  = total[22:1];
		recip = half * o2vpi_pkg::DIV5_MUL;
		quot  = total[24] ? '0 : recip[44:o2vpi_pkg::DIV5_SHIFT];
	end

	// Stage 5
	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			quot_s5 <= quot;
			en_s5   <= en_s4;
		end
	end

	// Saturate and pick the drive, floored at zero
	always_comb begin
		cmd = (quot_s5 > {4'b0000, cap_q}) ? cap_q : quot_s5[15:0];
		if (en_s5) begin
			drive = (off_level >= cmd) ? off_level - cmd : 16'd0;
		end else begin
			drive = off_level;
		end
	end

	// Stage 6: result register
	always_ff @(posedge clk) begin
		if (ctl.ld_s6) begin
			result_s6.valve_drive   <= drive;
			result_s6.valve_command <= cmd;
		end
	end

`ifndef NO_ASSERTIONS
	// A loaded command never exceeds the ceiling
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_s6 |=> result_s6.valve_command <= $past(cap_q))
		else $error("valve command above its ceiling");
`endif

endmodule

[hw/rtl/o2_valve_pi_controller.sv]
// Top level of the oxygen valve PI controller: config registers and pipeline control.
//
// Usage:
//  sample channel (sample_valid/sample_ready/sample) takes one control sample per beat;
//  result channel (result_valid/result_ready/result) returns one drive/command beat
//  for every sample, in order.
//  cfg_wen/cfg_index/cfg_data write one configuration register per cycle; unknown
//  indexes are ignored. Write only while no sample is in flight.
// Timing:
//  six-stage pipeline; stage 6 drives the result port. One sample per cycle sustained
//  while result_ready holds; the limit is the combinational add and clamp of the
//  integral accumulator, which every sample updates in turn.
// Stalls:
//  each stage holds while the one after it is full and blocked, so a waiting result
//  does not stop earlier stages from filling bubbles; sample_ready drops only when
//  every stage is occupied.
// Reset:
//  arst_n clears all stage valids, the integral accumulator and the configuration
//  registers to their defaults.
module o2_valve_pi_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  o2vpi_pkg::o2vpi_sample_t              sample,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output o2vpi_pkg::o2vpi_result_t              result,
	input  logic                                  cfg_wen,
	input  logic [o2vpi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [o2vpi_pkg::CFG_DATA_W-1:0]      cfg_data
);

	o2vpi_pkg::o2vpi_cfg_t cfg_q;
	o2vpi_pkg::o2vpi_ctl_t ctl;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	logic signed [o2vpi_pkg::ERR_W-1:0]  err_s1;
	logic                                en_s1, en_s2, en_s3, en_s4;
	logic signed [o2vpi_pkg::TERM_W-1:0] prop_s3;
	logic signed [o2vpi_pkg::TERM_W-1:0] inc_s3;
	logic signed [o2vpi_pkg::TERM_W-1:0] prop_s4;
	logic signed [o2vpi_pkg::ACC_W-1:0]  acc_s4;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= '0;
			cfg_q.integral_gain <= '0;
			cfg_q.integral_max  <= o2vpi_pkg::INTEGRAL_MAX_RST;
			cfg_q.integral_min  <= '0;
			cfg_q.off_level     <= o2vpi_pkg::OFF_LEVEL_RST;
			cfg_q.adjust_floor  <= o2vpi_pkg::ADJUST_FLOOR_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				o2vpi_pkg::REG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_data[15:0];
				o2vpi_pkg::REG_INTEGRAL_GAIN: cfg_q.integral_gain <= cfg_data[15:0];
				o2vpi_pkg::REG_INTEGRAL_MAX:  cfg_q.integral_max  <= cfg_data[19:0];
				o2vpi_pkg::REG_INTEGRAL_MIN:  cfg_q.integral_min  <= $signed(cfg_data);
				o2vpi_pkg::REG_OFF_LEVEL:     cfg_q.off_level     <= cfg_data[15:0];
				o2vpi_pkg::REG_ADJUST_FLOOR:  cfg_q.adjust_floor  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Per-stage ready: a stage loads when empty or when its contents move on
	always_comb begin
		rdy_s6 = !valid_s6 || result_ready;
		rdy_s5 = !valid_s5 || rdy_s6;
		rdy_s4 = !valid_s4 || rdy_s5;
		rdy_s3 = !valid_s3 || rdy_s4;
		rdy_s2 = !valid_s2 || rdy_s3;
		rdy_s1 = !valid_s1 || rdy_s2;
		ctl.ld_s2   = rdy_s2;
		ctl.ld_s3   = rdy_s3;
		ctl.ld_s4   = rdy_s4;
		ctl.acc_upd = valid_s3 && rdy_s4;
		ctl.ld_s5   = rdy_s5;
		ctl.ld_s6   = rdy_s6;
	end

	assign sample_ready = rdy_s1;
	assign result_valid = valid_s6;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= sample_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
			if (rdy_s6) valid_s6 <= valid_s5;
		end
	end

	// Stage 1: error and valve enable from the sample beat
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			err_s1 <= {sample.setpoint[15], sample.setpoint}
				- {sample.measured_flow[15], sample.measured_flow};
			en_s1  <= (sample.adjust_setting > cfg_q.adjust_floor)
				|| sample.full_oxygen_mode || sample.maintenance_on;
		end
	end

	// Carry the enable alongside the arithmetic
	always_ff @(posedge clk) begin
		if (rdy_s2) en_s2 <= en_s1;
		if (rdy_s3) en_s3 <= en_s2;
		if (rdy_s4) en_s4 <= en_s3;
	end

	o2vpi_gain_term u_prop_term (
		.clk     (clk),
		.ld_s2   (ctl.ld_s2),
		.ld_s3   (ctl.ld_s3),
		.gain    (cfg_q.prop_gain),
		.err     (err_s1),
		.term_s3 (prop_s3)
	);

	o2vpi_gain_term u_int_term (
		.clk     (clk),
		.ld_s2   (ctl.ld_s2),
		.ld_s3   (ctl.ld_s3),
		.gain    (cfg_q.integral_gain),
		.err     (err_s1),
		.term_s3 (inc_s3)
	);

	o2vpi_integrator u_integrator (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.prop_s3      (prop_s3),
		.inc_s3       (inc_s3),
		.integral_max (cfg_q.integral_max),
		.integral_min (cfg_q.integral_min),
		.prop_s4      (prop_s4),
		.acc_s4       (acc_s4)
	);

	o2vpi_cmd_out u_cmd_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.prop_s4      (prop_s4),
		.acc_s4       (acc_s4),
		.en_s4        (en_s4),
		.integral_max (cfg_q.integral_max),
		.off_level    (cfg_q.off_level),
		.result_s6    (result)
	);

`ifndef NO_ASSERTIONS
	// A sample blocked behind a full result stage stays in stage 5
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && !rdy_s6) |=> valid_s5)
		else $error("sample lost in front of the result stage");

	// The drive never opens past the closed level
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.valve_drive <= cfg_q.off_level)
		else $error("valve drive above off level");
`endif

endmodule
